/* rtl/zeas_pkg.sv */
`default_nettype none

package zeas_pkg;

  // One byte of the carved file
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Verdict given on the final byte
  typedef struct packed {
    logic        verdict;
    logic [33:0] archive_len;
  } out_t;

  // End-of-central-directory signature 50 4B 05 06
  localparam logic [23:0] SigHead = 24'h504B05;
  localparam logic [7:0]  SigTail = 8'h06;

  // Signature start offset must be 18 or more: last signature byte at 21 or more
  localparam int MinSigEnd       = 21;
  localparam int SigLen          = 3;
  localparam int MaxTailDistance = 65539;
  localparam int RecordLen       = 22;
  localparam int SizeWidth       = 34;

  // Record bytes captured after the signature, and where each field starts
  localparam logic [4:0] CaptureLen = 5'd18;
  localparam logic [4:0] SizeAt     = 5'd8;
  localparam logic [4:0] OffsetAt   = 5'd12;
  localparam logic [4:0] CommentAt  = 5'd16;

endpackage

`default_nettype wire

/* rtl/zip_eocd_archive_sizer.sv */
`default_nettype none

// Streams a carved file in one byte per transfer (last_byte flags the final
// byte) and gives one result on the final byte: verdict 1 with the archive size
// taken from the last end-of-central-directory record, or verdict 0 with size 0.
// Sustained rate is one byte per clock while in_ready_o is high. A byte is
// held in the input register while the scan logic updates its state, and the
// result lands in the output register behind it. in_ready_o drops only while
// a final byte waits behind a verdict that has not yet been taken. POS_WIDTH
// sets the width of the saturating byte position; a file of 2^POS_WIDTH bytes
// or more gives verdict 0.
module zip_eocd_archive_sizer #(
  parameter int POS_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire zeas_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output zeas_pkg::out_t      out_data_o
);

  logic           in_valid_q;
  zeas_pkg::in_t  in_q;
  logic           out_valid_q;
  zeas_pkg::out_t out_q;
  zeas_pkg::out_t result;
  logic           out_free;
  logic           step;

  // Stage advance: only a final byte needs room in the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (!in_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  zeas_scan #(
    .PosWidth(POS_WIDTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .result_o(result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_q.last_byte && out_valid_q && !out_ready_i)
    else $error("input stalled without a pending verdict");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(step && in_q.last_byte))
    else $error("verdict without a final byte");

  a_unknown_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.verdict |-> (out_q.archive_len == '0))
    else $error("size given with unknown verdict");

endmodule

`default_nettype wire

/* rtl/zeas_scan.sv */
`default_nettype none

module zeas_scan #(
  parameter int PosWidth = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire zeas_pkg::in_t item_i,
  output zeas_pkg::out_t     result_o
);

  localparam logic [PosWidth-1:0] PosMax = '1;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] sig_off_q, sig_off_d;
  logic [23:0]         recent_q, recent_d;
  logic                seen_q, seen_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [31:0]         dsize_q, dsize_d;
  logic [31:0]         doff_q, doff_d;
  logic [15:0]         clen_q, clen_d;

  logic                pos_max;
  logic                sig_hit;
  logic [PosWidth-1:0] tail_dist;
  logic [PosWidth-1:0] need;
  logic                fits;

  // Next state for one byte
  always_comb begin
    pos_max   = (pos_q == PosMax);
    seen_d    = seen_q;
    sig_off_d = sig_off_q;
    cnt_d     = cnt_q;
    dsize_d   = dsize_q;
    doff_d    = doff_q;
    clen_d    = clen_q;

    // capture record bytes behind the latest signature, little endian
    if (seen_q && (cnt_q < zeas_pkg::CaptureLen)) begin
      if (cnt_q >= zeas_pkg::CommentAt) begin
        clen_d[{cnt_q[0], 3'b000} +: 8] = item_i.data_byte;
      end else if (cnt_q >= zeas_pkg::OffsetAt) begin
        doff_d[{cnt_q[1:0], 3'b000} +: 8] = item_i.data_byte;
      end else if (cnt_q >= zeas_pkg::SizeAt) begin
        dsize_d[{cnt_q[1:0], 3'b000} +: 8] = item_i.data_byte;
      end
      cnt_d = cnt_q + 5'd1;
    end

    // a newer signature restarts the capture
    sig_hit = (recent_q == zeas_pkg::SigHead) && (item_i.data_byte == zeas_pkg::SigTail) &&
              (pos_q >= PosWidth'(zeas_pkg::MinSigEnd)) && !pos_max;
    if (sig_hit) begin
      seen_d    = 1'b1;
      sig_off_d = pos_q - PosWidth'(zeas_pkg::SigLen);
      cnt_d     = '0;
    end

    recent_d = {recent_q[15:0], item_i.data_byte};
    pos_d    = pos_max ? pos_q : pos_q + PosWidth'(1);
  end

  // Verdict on the state after this byte; file length is pos_q + 1
  always_comb begin
    tail_dist = pos_q + PosWidth'(1) - sig_off_d;
    need      = PosWidth'(zeas_pkg::RecordLen) + PosWidth'(clen_d);
    fits = !pos_max && seen_d && (cnt_d == zeas_pkg::CaptureLen) &&
           (tail_dist <= PosWidth'(zeas_pkg::MaxTailDistance)) && (need <= tail_dist);
    result_o.verdict     = fits;
    result_o.archive_len = '0;
    if (fits) begin
      result_o.archive_len = zeas_pkg::SizeWidth'(doff_d) + zeas_pkg::SizeWidth'(dsize_d) +
                             zeas_pkg::SizeWidth'(zeas_pkg::RecordLen) +
                             zeas_pkg::SizeWidth'(clen_d);
    end
  end

  // Control state; the final byte returns it to the start of a file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sig_off_q <= '0;
      recent_q  <= '0;
      seen_q    <= 1'b0;
      cnt_q     <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q     <= '0;
        sig_off_q <= '0;
        recent_q  <= '0;
        seen_q    <= 1'b0;
        cnt_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        sig_off_q <= sig_off_d;
        recent_q  <= recent_d;
        seen_q    <= seen_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  // Captured fields: only read once all 18 bytes after the signature are in
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dsize_q <= dsize_d;
      doff_q  <= doff_d;
      clen_q  <= clen_d;
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= zeas_pkg::CaptureLen)
    else $error("capture count out of range");

  a_eof_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> (pos_q == '0) && !seen_q)
    else $error("state not cleared after final byte");

  a_capture_needs_sig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (cnt_q == '0))
    else $error("capture count without signature");

endmodule

`default_nettype wire
